### rtl/dbr_pkg.sv
`timescale 1ns / 1ps

package dbr_pkg;

	// Default build of the sample path.
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed widths of the value path and the register file.
	localparam int VALUE_BITS     = 32;
	localparam int THR_BITS       = 31;
	localparam int COUNT_BITS     = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// Register map of the configuration port.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GAIN         = 3'd0,
		REG_OFFSET       = 3'd1,
		REG_THRESHOLD    = 3'd2,
		REG_REPORT_EVERY = 3'd3,
		REG_ALARM_ENABLE = 3'd4,
		REG_WINDOW_LOW   = 3'd5,
		REG_WINDOW_HIGH  = 3'd6
	} dbr_reg_t;

	// Settings the report and alarm tracker works from.
	typedef struct packed {
		logic [THR_BITS-1:0]          threshold;
		logic [COUNT_BITS-1:0]        report_every;
		logic                         alarm_enable;
		logic signed [VALUE_BITS-1:0] window_low;
		logic signed [VALUE_BITS-1:0] window_high;
	} dbr_track_cfg_t;

	// Per-word status flags produced by the tracker.
	typedef struct packed {
		logic report;
		logic alarm_raised;
		logic alarm_latched;
	} dbr_flags_t;

endpackage

### rtl/dbr_scale.sv
`timescale 1ns / 1ps

module dbr_scale #(
	parameter int SAMPLE_BITS = dbr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   load,
	input  logic [SAMPLE_BITS-1:0]                 sample_s1,
	input  logic signed [dbr_pkg::VALUE_BITS-1:0]  gain,
	input  logic signed [dbr_pkg::VALUE_BITS-1:0]  offset,
	output logic signed [dbr_pkg::VALUE_BITS-1:0]  value_s2
);

	localparam int VB   = dbr_pkg::VALUE_BITS;
	localparam int PW   = SAMPLE_BITS + 1 + VB;
	localparam int SUMW = PW + 1;

	logic signed [PW-1:0]   prod;
	logic signed [SUMW-1:0] sum;
	logic [SUMW-VB:0]       top_bits;
	logic signed [VB-1:0]   sat;

	// Sample is unsigned, so it enters the multiplier with a zero sign bit.
	assign prod = $signed({1'b0, sample_s1}) * gain;
	assign sum  = $signed({prod[PW-1], prod}) + $signed({{(SUMW-VB){offset[VB-1]}}, offset});

	// The sum fits when every bit from the 32-bit sign position up agrees.
	assign top_bits = sum[SUMW-1:VB-1];

	always_comb begin
		if ((top_bits == '0) || (top_bits == '1)) begin
			sat = sum[VB-1:0];
		end else if (sum[SUMW-1]) begin
			sat = {1'b1, {(VB-1){1'b0}}};
		end else begin
			sat = {1'b0, {(VB-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_s2 <= sat;
		end
	end

endmodule

### rtl/dbr_track.sv
`timescale 1ns / 1ps

module dbr_track #(
	parameter int FRAC_BITS = dbr_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fire,
	input  logic signed [dbr_pkg::VALUE_BITS-1:0] value_s2,
	input  dbr_pkg::dbr_track_cfg_t               cfg,
	output dbr_pkg::dbr_flags_t                   flags_q
);

	localparam int VB = dbr_pkg::VALUE_BITS;
	localparam int CB = dbr_pkg::COUNT_BITS;
	// One tenth in fixed point, rounded down.
	localparam logic [VB:0] TENTH = (VB+1)'((64'd1 << FRAC_BITS) / 10);

	logic signed [VB-1:0] last_q;
	logic [CB-1:0]        since_q;
	logic                 latch_q;

	logic [CB-1:0]        since_next;
	logic signed [VB:0]   diff;
	logic [VB:0]          diff_mag;
	logic signed [VB:0]   win_diff;
	logic [VB:0]          win_mag;
	logic signed [VB:0]   value_x;
	logic signed [VB:0]   rearm_lo;
	logic signed [VB:0]   rearm_hi;
	logic                 report;
	logic                 wide;
	logic                 outside;
	logic                 in_band;
	logic                 raise;
	logic                 clear;

	assign since_next = since_q + CB'(1);
	assign value_x    = {value_s2[VB-1], value_s2};
	assign diff       = value_x - $signed({last_q[VB-1], last_q});
	assign diff_mag   = diff[VB] ? (VB+1)'(-diff) : diff;
	assign report     = (diff_mag > {2'b00, cfg.threshold}) || (since_next >= cfg.report_every);

	assign win_diff = $signed({cfg.window_low[VB-1], cfg.window_low})
		- $signed({cfg.window_high[VB-1], cfg.window_high});
	assign win_mag  = win_diff[VB] ? (VB+1)'(-win_diff) : win_diff;
	assign wide     = win_mag > TENTH;
	assign outside  = (value_s2 < cfg.window_low) || (value_s2 > cfg.window_high);

	// Re-arm band is the window shrunk by the threshold on both sides.
	assign rearm_lo = $signed({cfg.window_low[VB-1], cfg.window_low}) + $signed({2'b00, cfg.threshold});
	assign rearm_hi = $signed({cfg.window_high[VB-1], cfg.window_high}) - $signed({2'b00, cfg.threshold});
	assign in_band  = (value_x > rearm_lo) && (value_x < rearm_hi);

	assign raise = report && cfg.alarm_enable && !latch_q && wide && outside;
	assign clear = report && cfg.alarm_enable && latch_q && in_band;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			since_q <= '0;
			latch_q <= 1'b0;
		end else if (fire) begin
			if (report) begin
				last_q  <= value_s2;
				since_q <= '0;
			end else begin
				since_q <= since_next;
			end
			if (raise) begin
				latch_q <= 1'b1;
			end else if (clear) begin
				latch_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_q.report        <= report;
			flags_q.alarm_raised  <= raise;
			flags_q.alarm_latched <= (latch_q || raise) && !clear;
		end
	end

`ifndef SYNTHESIS
	a_report_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && report |=> since_q == '0 && last_q == $past(value_s2))
		else $error("report did not clear the sample count or store the value");

	a_raise_sets_latch: assert property (@(posedge clk) disable iff (!arst_n)
		fire && raise |=> latch_q && flags_q.report && flags_q.alarm_raised)
		else $error("alarm fired without a report or without setting the latch");

	a_disabled_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg.alarm_enable |=> $stable(latch_q) && !flags_q.alarm_raised)
		else $error("alarm latch moved while the alarm was disabled");

	a_latch_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> flags_q.alarm_latched == latch_q)
		else $error("reported latch state differs from the latch");
`endif

endmodule

### rtl/deadband_reporter_with_window_alarm.sv
`timescale 1ns / 1ps

// Send-on-delta reporter with a latched out-of-window alarm.
// Input channel (in_valid/in_ready/sample) carries one raw ADC word. Every word
// yields exactly one result word on the output channel (out_valid/out_ready):
// the scaled, saturated value sample*gain+offset, the raw sample, a report flag,
// the alarm-fired flag and the alarm latch state after this sample.
// Pipeline: three register stages (input, scale, track). Throughput: one word
// per cycle while out_ready does not stall the output; the multiplier in the
// scale stage and the compare logic in the track stage are combinational in
// their stage, and only the track stage carries state from one word to the next.
// A stall on out_ready holds the result; the stages behind it keep filling
// until all three hold a word, then in_ready drops.
// Reset (arst_n low) empties the pipeline, clears the last reported value, the
// sample count and the alarm latch, and loads the register defaults: gain 1.0,
// report every sample, alarm disabled. The user must write the registers through
// cfg_write/cfg_index/cfg_data only while no word is in flight (not enforced).
module deadband_reporter_with_window_alarm #(
	parameter int SAMPLE_BITS = dbr_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = dbr_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [dbr_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [dbr_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [SAMPLE_BITS-1:0]                   sample,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     report,
	output logic signed [dbr_pkg::VALUE_BITS-1:0]    scaled_value,
	output logic [SAMPLE_BITS-1:0]                   raw_echo,
	output logic                                     alarm_raised,
	output logic                                     alarm_latched
);

	localparam int VB = dbr_pkg::VALUE_BITS;

	// Configuration registers.
	logic signed [VB-1:0]    gain_q;
	logic signed [VB-1:0]    offset_q;
	dbr_pkg::dbr_track_cfg_t track_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q                   <= VB'(64'd1 << FRAC_BITS);
			offset_q                 <= '0;
			track_cfg_q.threshold    <= '0;
			track_cfg_q.report_every <= dbr_pkg::COUNT_BITS'(1);
			track_cfg_q.alarm_enable <= 1'b0;
			track_cfg_q.window_low   <= '0;
			track_cfg_q.window_high  <= '0;
		end else if (cfg_write) begin
			case (dbr_pkg::dbr_reg_t'(cfg_index))
				dbr_pkg::REG_GAIN:         gain_q <= cfg_data;
				dbr_pkg::REG_OFFSET:       offset_q <= cfg_data;
				dbr_pkg::REG_THRESHOLD:    track_cfg_q.threshold <= cfg_data[dbr_pkg::THR_BITS-1:0];
				dbr_pkg::REG_REPORT_EVERY: begin
					track_cfg_q.report_every <= cfg_data[dbr_pkg::COUNT_BITS-1:0];
				end
				dbr_pkg::REG_ALARM_ENABLE: track_cfg_q.alarm_enable <= cfg_data[0];
				dbr_pkg::REG_WINDOW_LOW:   track_cfg_q.window_low <= cfg_data;
				dbr_pkg::REG_WINDOW_HIGH:  track_cfg_q.window_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline occupancy and per-stage advance. A stage moves when it is empty
	// or when the stage ahead of it moves.
	logic valid_s1_q;
	logic valid_s2_q;
	logic out_valid_q;
	logic adv1;
	logic adv2;
	logic adv3;

	assign adv3     = !out_valid_q || out_ready;
	assign adv2     = !valid_s2_q || adv3;
	assign adv1     = !valid_s1_q || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			valid_s2_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1_q <= in_valid;
			end
			if (adv2) begin
				valid_s2_q <= valid_s1_q;
			end
			if (adv3) begin
				out_valid_q <= valid_s2_q;
			end
		end
	end

	// Sample payload through the stages.
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] raw_s2;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic signed [VB-1:0]   value_s2;
	logic signed [VB-1:0]   value_q;
	logic                   load2;
	logic                   fire3;

	assign load2 = adv2 && valid_s1_q;
	assign fire3 = adv3 && valid_s2_q;

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sample_s1 <= sample;
		end
		if (load2) begin
			raw_s2 <= sample_s1;
		end
		if (fire3) begin
			raw_q   <= raw_s2;
			value_q <= value_s2;
		end
	end

	dbr_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk      (clk),
		.load     (load2),
		.sample_s1(sample_s1),
		.gain     (gain_q),
		.offset   (offset_q),
		.value_s2 (value_s2)
	);

	dbr_pkg::dbr_flags_t flags_q;

	dbr_track #(
		.FRAC_BITS(FRAC_BITS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire3),
		.value_s2(value_s2),
		.cfg     (track_cfg_q),
		.flags_q (flags_q)
	);

	assign out_valid     = out_valid_q;
	assign scaled_value  = value_q;
	assign raw_echo      = raw_q;
	assign report        = flags_q.report;
	assign alarm_raised  = flags_q.alarm_raised;
	assign alarm_latched = flags_q.alarm_latched;

endmodule

### tb/sv/deadband_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the deadband reporter. Each
// accepted sample word is run through a local copy of the scaling, report and
// alarm logic, and each result word is compared field by field with the oldest
// expectation.
module deadband_result_checker #(
	parameter int SAMPLE_BITS = dbr_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = dbr_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [dbr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [dbr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [SAMPLE_BITS-1:0]                sample,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic                                  report,
	input  logic signed [dbr_pkg::VALUE_BITS-1:0] scaled_value,
	input  logic [SAMPLE_BITS-1:0]                raw_echo,
	input  logic                                  alarm_raised,
	input  logic                                  alarm_latched,
	output int                                    mismatch_count,
	output int                                    words_outstanding
);

	localparam int     VB         = dbr_pkg::VALUE_BITS;
	localparam longint VALUE_MAX  = 64'sd2147483647;
	localparam longint VALUE_MIN  = -64'sd2147483648;
	localparam longint MIN_SPAN   = (longint'(1) << FRAC_BITS) / 10;
	localparam int     MAX_LINES  = 50;

	typedef struct packed {
		logic                 report;
		logic signed [VB-1:0] value;
		logic [SAMPLE_BITS-1:0] raw;
		logic                 raised;
		logic                 latched;
	} result_word_t;

	// Register copy.
	logic signed [VB-1:0]                 gain_q;
	logic signed [VB-1:0]                 offset_q;
	logic [dbr_pkg::THR_BITS-1:0]         thr_q;
	logic [dbr_pkg::COUNT_BITS-1:0]       every_q;
	logic                                 alarm_en_q;
	logic signed [VB-1:0]                 win_lo_q;
	logic signed [VB-1:0]                 win_hi_q;

	// Tracker state.
	logic signed [VB-1:0]                 last_value_q;
	logic [dbr_pkg::COUNT_BITS-1:0]       since_q;
	logic                                 latch_q;

	result_word_t expected_words[$];

	function automatic result_word_t scale_and_track(input logic [SAMPLE_BITS-1:0] raw);
		longint       scaled;
		longint       delta;
		longint       span;
		result_word_t res;
		scaled = longint'(raw) * longint'(gain_q) + longint'(offset_q);
		if (scaled > VALUE_MAX)
			scaled = VALUE_MAX;
		else if (scaled < VALUE_MIN)
			scaled = VALUE_MIN;
		since_q = since_q + 1'b1;
		delta = scaled - longint'(last_value_q);
		if (delta < 0)
			delta = -delta;
		res.report = (delta > longint'(thr_q)) || (since_q >= every_q);
		res.raised = 1'b0;
		if (res.report) begin
			last_value_q = scaled[VB-1:0];
			since_q = '0;
			if (alarm_en_q) begin
				span = longint'(win_lo_q) - longint'(win_hi_q);
				if (span < 0)
					span = -span;
				if (!latch_q && span > MIN_SPAN &&
				    (scaled < longint'(win_lo_q) || scaled > longint'(win_hi_q))) begin
					latch_q = 1'b1;
					res.raised = 1'b1;
				end else if (latch_q &&
				             scaled > longint'(win_lo_q) + longint'(thr_q) &&
				             scaled < longint'(win_hi_q) - longint'(thr_q)) begin
					latch_q = 1'b0;
				end
			end
		end
		res.value = scaled[VB-1:0];
		res.raw = raw;
		res.latched = latch_q;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_LINES)
			$display("%0t: result mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_result_word();
		result_word_t want;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("result word (raw %0d) with no sample outstanding",
				raw_echo));
		end else begin
			want = expected_words.pop_front();
			if (report !== want.report)
				report_mismatch($sformatf("report %0b, expected %0b", report, want.report));
			if (scaled_value !== want.value)
				report_mismatch($sformatf("scaled_value %0d, expected %0d",
					scaled_value, want.value));
			if (raw_echo !== want.raw)
				report_mismatch($sformatf("raw_echo %0d, expected %0d", raw_echo, want.raw));
			if (alarm_raised !== want.raised)
				report_mismatch($sformatf("alarm_raised %0b, expected %0b",
					alarm_raised, want.raised));
			if (alarm_latched !== want.latched)
				report_mismatch($sformatf("alarm_latched %0b, expected %0b",
					alarm_latched, want.latched));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q = VB'(longint'(1) << FRAC_BITS);
			offset_q = '0;
			thr_q = '0;
			every_q = 8'd1;
			alarm_en_q = 1'b0;
			win_lo_q = '0;
			win_hi_q = '0;
			last_value_q = '0;
			since_q = '0;
			latch_q = 1'b0;
			expected_words.delete();
			mismatch_count = 0;
			words_outstanding = 0;
		end else begin
			// A result can never belong to a sample taken at the same edge,
			// so the output side is settled first.
			if (out_valid && out_ready)
				check_result_word();
			if (in_valid && in_ready)
				expected_words.push_back(scale_and_track(sample));
			if (cfg_write) begin
				case (cfg_index)
					dbr_pkg::REG_GAIN:         gain_q = cfg_data;
					dbr_pkg::REG_OFFSET:       offset_q = cfg_data;
					dbr_pkg::REG_THRESHOLD:    thr_q = cfg_data[dbr_pkg::THR_BITS-1:0];
					dbr_pkg::REG_REPORT_EVERY: every_q = cfg_data[dbr_pkg::COUNT_BITS-1:0];
					dbr_pkg::REG_ALARM_ENABLE: alarm_en_q = cfg_data[0];
					dbr_pkg::REG_WINDOW_LOW:   win_lo_q = cfg_data;
					dbr_pkg::REG_WINDOW_HIGH:  win_hi_q = cfg_data;
					default: ;
				endcase
			end
			words_outstanding = expected_words.size();
		end
	end

endmodule

### tb/sv/deadband_reporter_with_window_alarm_test.sv
`timescale 1ns / 1ps

// Top of the deadband reporter testbench. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the checker that
// sits beside the block and watches the same wires.
module deadband_reporter_with_window_alarm_test;

	localparam int SB = dbr_pkg::SAMPLE_BITS_DEF;
	localparam int VB = dbr_pkg::VALUE_BITS;

	// One in Q16.16.
	localparam logic [31:0] UNITY = 32'h0001_0000;
	// Smallest window span that still lets the alarm fire is one above this.
	localparam int TENTH = 6553;

	localparam int RANDOM_WORDS      = 750;
	localparam int LONG_HOLD_CYCLES  = 48;
	localparam int DRAIN_LIMIT       = 5000;
	localparam int SETTLE_CYCLES     = 4;
	// Dozens of times what the slowest correct run needs.
	localparam longint RUN_LIMIT_NS  = 64'd8_000_000;

	// The register map leaves index seven unused; writes to it must be ignored.
	localparam logic [dbr_pkg::CFG_INDEX_BITS-1:0] UNUSED_INDEX = 3'd7;

	// Ways the receiver can pace out_ready between long hold-offs.
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_write;
	logic [dbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
	logic [dbr_pkg::CFG_DATA_BITS-1:0]   cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [SB-1:0]                       sample;
	logic                                out_valid;
	logic                                out_ready;
	logic                                report;
	logic signed [VB-1:0]                scaled_value;
	logic [SB-1:0]                       raw_echo;
	logic                                alarm_raised;
	logic                                alarm_latched;

	int mismatch_count;
	int words_outstanding;
	int words_sent;

	// The stimulus process bumps the request count to ask for a long stall;
	// the receiver process catches up once it has held off.
	int long_hold_req = 0;
	int long_hold_done = 0;

	deadband_reporter_with_window_alarm #(
		.SAMPLE_BITS (SB),
		.FRAC_BITS   (dbr_pkg::FRAC_BITS_DEF)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.report        (report),
		.scaled_value  (scaled_value),
		.raw_echo      (raw_echo),
		.alarm_raised  (alarm_raised),
		.alarm_latched (alarm_latched)
	);

	deadband_result_checker #(
		.SAMPLE_BITS (SB),
		.FRAC_BITS   (dbr_pkg::FRAC_BITS_DEF)
	) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample            (sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.report            (report),
		.scaled_value      (scaled_value),
		.raw_echo          (raw_echo),
		.alarm_raised      (alarm_raised),
		.alarm_latched     (alarm_latched),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	// 20 ns clock. All inputs move on the falling edge, so the block and the
	// checker both see settled values at the rising edge.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one sample word and hold it until the block takes it. Valid stays
	// high on return so that a following word goes out back to back.
	task automatic push_word(input logic [SB-1:0] value);
		@(negedge clk);
		in_valid = 1'b1;
		sample = value;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// Drop valid for a number of cycles, with junk on the data lines.
	task automatic idle_gap(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid = 1'b0;
			sample = SB'($urandom);
		end
	endtask

	// Stop sending and wait until every outstanding result has come back.
	// Every sample makes a result, so once the count is zero the pipeline is
	// empty; the task still waits SETTLE_CYCLES more before touching registers.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (words_outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [dbr_pkg::CFG_INDEX_BITS-1:0] index,
	                         input logic [dbr_pkg::CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// Bring the block to idle and load a full register set.
	task automatic set_regs(input logic [31:0] gain, input logic [31:0] offset,
	                        input logic [31:0] thr, input logic [31:0] every,
	                        input logic [31:0] enable, input logic [31:0] win_lo,
	                        input logic [31:0] win_hi);
		drain();
		write_reg(dbr_pkg::REG_GAIN, gain);
		write_reg(dbr_pkg::REG_OFFSET, offset);
		write_reg(dbr_pkg::REG_THRESHOLD, thr);
		write_reg(dbr_pkg::REG_REPORT_EVERY, every);
		write_reg(dbr_pkg::REG_ALARM_ENABLE, enable);
		write_reg(dbr_pkg::REG_WINDOW_LOW, win_lo);
		write_reg(dbr_pkg::REG_WINDOW_HIGH, win_hi);
	endtask

	// Receiver: a randomly chosen pacing pattern that changes after a random
	// run of cycles, with stretches of full readiness, plus a long hold-off whenever
	// the stimulus asks for one. The hold-off is counted here, in cycles.
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		rx_mode = RX_OPEN;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req != long_hold_done) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
				long_hold_done = long_hold_req;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 64);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN:   out_ready = 1'b1;
					RX_COIN:   out_ready = 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
					default:   out_ready = ~out_ready;
				endcase
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] gain_w;
		logic [31:0] offset_w;
		logic [31:0] thr_w;
		logic [31:0] every_w;
		logic [31:0] enable_w;
		logic [31:0] win_lo_w;
		logic [31:0] win_hi_w;
		int          lo_s;
		int          hi_s;
		int          level;
		int          phase;
		int          phase_left;
		int          burst;
		int          wait_cycles;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = dbr_pkg::REG_GAIN;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		words_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---------------- Directed part ----------------

		// Register defaults: unity gain, every sample reported. Field extremes
		// and a repeated value.
		push_word(10'd0);
		push_word(10'd1023);
		push_word(10'd512);
		push_word(10'd512);
		push_word(10'd1);

		// Saturation at the top: largest gain and offset.
		set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
		push_word(10'd1023);
		push_word(10'd0);
		// Saturation at the bottom: most negative gain and offset.
		set_regs(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
		push_word(10'd1023);

		// Zero interval reports every sample even with the largest threshold.
		// Bits above each register's width are set and must be dropped.
		set_regs(UNITY, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFE,
		         32'd0, 32'd0);
		push_word(10'd5);
		push_word(10'd5);

		// Forced report on the third quiet sample, then a report on a jump
		// larger than the threshold.
		set_regs(UNITY, 32'd0, 32'(10) << 16, 32'd3, 32'd0, 32'd0, 32'd0);
		push_word(10'd100);
		push_word(10'd100);
		push_word(10'd100);
		push_word(10'd100);
		push_word(10'd200);

		// Window alarm with hysteresis: in range, fire, stay latched, inside
		// the window but within the margin, re-arm, fire again below.
		set_regs(UNITY, 32'd0, 32'(5) << 16, 32'd1, 32'hFFFF_FFFF,
		         32'(100) << 16, 32'(200) << 16);
		push_word(10'd150);
		push_word(10'd250);
		push_word(10'd260);
		push_word(10'd198);
		push_word(10'd150);
		push_word(10'd50);

		// Narrow window: the span equals the tenth exactly, so nothing fires.
		set_regs(UNITY, 32'd0, 32'd0, 32'd1, 32'd1,
		         32'(100) << 16, (32'(100) << 16) + TENTH);
		push_word(10'd300);

		// Inverted window: every value is outside, and the latch cannot clear.
		set_regs(UNITY, 32'd0, 32'd0, 32'd1, 32'd1, 32'(200) << 16, 32'(100) << 16);
		push_word(10'd150);
		push_word(10'd150);

		// Alarm disabled: the latch holds what it had.
		set_regs(UNITY, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFE, 32'(200) << 16,
		         32'(100) << 16);
		push_word(10'd300);

		// ---------------- Random part ----------------

		words_sent = 0;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			phase++;

			case ($urandom_range(0, 9))
				0:       gain_w = 32'h7FFF_FFFF;
				1:       gain_w = 32'h8000_0000;
				2:       gain_w = $urandom;
				default: begin
					gain_w = $urandom_range(0, 4 << 16);
					if ($urandom_range(0, 3) == 0)
						gain_w = -gain_w;
				end
			endcase
			case ($urandom_range(0, 9))
				0:       offset_w = 32'h7FFF_FFFF;
				1:       offset_w = 32'h8000_0000;
				2:       offset_w = $urandom;
				default: offset_w = $urandom_range(0, 2000 << 16) - (1000 << 16);
			endcase
			case ($urandom_range(0, 9))
				0:       thr_w = 32'd0;
				1:       thr_w = 32'hFFFF_FFFF;
				2:       thr_w = $urandom;
				default: begin
					thr_w = $urandom_range(0, 40 << 16);
					thr_w[31] = 1'($urandom_range(0, 1));
				end
			endcase
			every_w = $urandom;
			case ($urandom_range(0, 7))
				0:       every_w[7:0] = 8'd0;
				1:       every_w[7:0] = 8'd255;
				2, 3:    every_w[7:0] = 8'($urandom_range(0, 255));
				default: every_w[7:0] = 8'($urandom_range(1, 8));
			endcase
			enable_w = $urandom;
			enable_w[0] = ($urandom_range(0, 3) != 0);

			// Put the window where the scaled samples actually land, so that
			// the alarm both fires and re-arms; sometimes narrow or arbitrary.
			lo_s = $urandom_range(0, 1023);
			hi_s = $urandom_range(0, 1023);
			win_lo_w = 32'($signed(gain_w) * longint'(lo_s) + $signed(offset_w));
			win_hi_w = 32'($signed(gain_w) * longint'(hi_s) + $signed(offset_w));
			case ($urandom_range(0, 7))
				0:       win_hi_w = win_lo_w + $urandom_range(0, 2 * TENTH);
				1: begin
					win_lo_w = $urandom;
					win_hi_w = $urandom;
				end
				default: ;
			endcase

			set_regs(gain_w, offset_w, thr_w, every_w, enable_w, win_lo_w, win_hi_w);
			if ($urandom_range(0, 3) == 0)
				write_reg(UNUSED_INDEX, $urandom);

			// Now and then stall the receiver for a long stretch and stream
			// words back to back, so the pipeline fills and in_ready drops.
			if (phase == 2 || $urandom_range(0, 5) == 0) begin
				long_hold_req++;
				repeat (24) push_word(SB'($urandom));
			end

			// Most words follow a slow random walk, so the deadband and the
			// interval both decide reports; the rest are jumps and extremes.
			level = $urandom_range(0, 1023);
			phase_left = $urandom_range(30, 90);
			while (phase_left > 0) begin
				burst = $urandom_range(1, 20);
				if (burst > phase_left)
					burst = phase_left;
				phase_left -= burst;
				repeat (burst) begin
					case ($urandom_range(0, 15))
						0:       push_word(SB'(0));
						1:       push_word(SB'(1023));
						2:       push_word(SB'($urandom));
						3: begin
							level = $urandom_range(0, 1023);
							push_word(SB'(level));
						end
						default: begin
							level += $urandom_range(0, 8) - 4;
							if (level < 0)
								level = 0;
							if (level > 1023)
								level = 1023;
							push_word(SB'(level));
						end
					endcase
				end
				if ($urandom_range(0, 2) != 0)
					idle_gap($urandom_range(1, 6));
			end
		end

		// ---------------- Wrap-up ----------------

		@(negedge clk);
		in_valid = 1'b0;
		wait_cycles = 0;
		while (words_outstanding != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (words_outstanding == 0 && mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
